### src/kmhq_pkg.sv
// Package for the k-ary min-heap queue: defaults, status codes, states.
// No dependencies.
`default_nettype none
package kmhq_pkg;
	localparam int CAPACITY_DEF  = 1024;
	localparam int MAX_ARITY_DEF = 8;
	localparam logic [3:0] ARITY_RESET = 4'd3;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_UP_RD,
		S_UP_CMP,
		S_RM_RD,
		S_RM_LAST,
		S_DN_PAR,
		S_DN_CH,
		S_DN_WR,
		S_DONE
	} state_t;
endpackage
`default_nettype wire

### src/kary_min_heap_queue_top.sv
// k-ary min-heap queue: control sequencer around one key+element store.
// Depends on kmhq_pkg.
//
// Usage:
//   s_axis carries one operation per transfer (tuser 0 insert, 1 remove min);
//   m_axis returns one result per operation. cfg writes the arity (values
//   below 2 act as 2, above MAX_ARITY as MAX_ARITY); write it only while idle.
//   One operation is handled at a time. s_axis_tready is high only while the
//   sequencer is idle, so the next operation waits until it is back in idle.
//   Steps from the input transfer to m_axis_tvalid:
//     insert: per level it climbs, read the parent and compare, then write;
//     remove: read the root, then the last entry, then for each node visited
//       on the way down read its c children (c <= k) one per cycle through
//       the single read port of the store; removing the only entry skips the walk;
//     insert on full, remove on empty: straight to the result.
//   The result moves into an output register. While it waits for the receiver
//   the next operation is accepted and processed; its result then holds in the
//   sequencer until the output register is free.
//   Reset clears the entry count, the arity (to 3) and the output valid; the
//   store itself is not cleared, as only entries below the count are read.
`default_nettype none
module kary_min_heap_queue_top
	import kmhq_pkg::*;
#(
	parameter int CAPACITY  = CAPACITY_DEF,
	parameter int MAX_ARITY = MAX_ARITY_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [3:0]  cfg_data,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// tdata: elem_in[31:0], key_in[63:32]
	input  wire logic [63:0] s_axis_tdata,
	// tuser: func
	input  wire logic        s_axis_tuser,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// tdata: elem_out[31:0], key_out[63:32], status[65:64], count_out[76:66], pad
	output logic [79:0]      m_axis_tdata
);
	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = AW + 6; // room for k*i+k with k up to 16
	localparam int PS = IW + 5; // reciprocal scale, exact for any IW-bit dividend

	// store: {key, elem}
	logic [63:0] mem [CAPACITY];
	logic [63:0] rd_q;
	logic [AW-1:0] ra, wa;
	logic we;
	logic [63:0] wd;
	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		rd_q <= mem[ra];
	end

	state_t st_q, st_d;
	logic [3:0] ar_q;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [IW-1:0] i_q, i_d, c_q, c_d, best_q, best_d, end_q, end_d;
	logic [63:0] cur_q, cur_d, bestv_q, bestv_d;
	logic [63:0] res_q, res_d;
	logic [1:0] stat_q, stat_d;
	logic [79:0] out_q, out_d;
	logic ov_q, ov_d;

	logic [IW-1:0] k;
	always_comb begin
		if (ar_q < 4'd2) k = IW'(2);
		else if (32'(ar_q) > MAX_ARITY) k = IW'(MAX_ARITY);
		else k = IW'(ar_q);
	end

	// reciprocals ceil(2^PS / t) for every arity t
	wire [(MAX_ARITY-1)*PS-1:0] rcp_tab;
	for (genvar g = 2; g <= MAX_ARITY; g++) begin : g_rcp
		localparam longint GK = g;
		localparam longint RC = ((longint'(1) << PS) + GK - 1) / GK;
		assign rcp_tab[(g-2)*PS +: PS] = PS'(RC);
	end

	// parent index (i-1)/k by reciprocal multiplication
	logic [PS-1:0] rcp;
	logic [IW-1:0] ix;
	logic [IW+PS-1:0] prod;
	logic [IW-1:0] par;
	always_comb begin
		rcp = rcp_tab[PS-1:0];
		for (int t = 2; t <= MAX_ARITY; t++)
			if (k == IW'(t)) rcp = rcp_tab[(t-2)*PS +: PS];
		ix = i_q - IW'(1);
		prod = (IW+PS)'(ix) * (IW+PS)'(rcp);
		par = prod[IW+PS-1:PS];
	end

	assign cfg_ready = (st_q == S_IDLE);
	assign s_axis_tready = (st_q == S_IDLE);
	assign m_axis_tvalid = ov_q;
	assign m_axis_tdata = out_q;

	logic key_lt;
	logic signed [31:0] ka, kb;
	always_comb begin
		ka = rd_q[63:32];
		kb = bestv_q[63:32];
	end

	always_comb begin
		st_d = st_q; cnt_d = cnt_q; i_d = i_q; c_d = c_q; best_d = best_q;
		end_d = end_q; cur_d = cur_q; bestv_d = bestv_q; res_d = res_q;
		stat_d = stat_q; ov_d = ov_q; out_d = out_q;
		we = 1'b0; wa = '0; wd = cur_q; ra = AW'(i_q);
		key_lt = 1'b0;
		if (ov_q && m_axis_tready) ov_d = 1'b0;
		case (st_q)
			S_IDLE: begin
				if (s_axis_tvalid) begin
					res_d = '0; stat_d = ST_OK;
					if (!s_axis_tuser) begin
						if (32'(cnt_q) >= CAPACITY) begin
							stat_d = ST_FULL; st_d = S_DONE;
						end else begin
							cur_d = {s_axis_tdata[63:32], s_axis_tdata[31:0]};
							i_d = IW'(cnt_q);
							cnt_d = cnt_q + CW'(1);
							st_d = S_UP_RD;
						end
					end else begin
						if (cnt_q == '0) begin
							stat_d = ST_EMPTY; st_d = S_DONE;
						end else begin
							cnt_d = cnt_q - CW'(1);
							st_d = S_RM_RD;
						end
					end
				end
			end
			S_UP_RD: begin
				if (i_q == '0) begin
					we = 1'b1; wa = '0; st_d = S_DONE;
				end else begin
					ra = AW'(par); st_d = S_UP_CMP;
				end
			end
			S_UP_CMP: begin
				// rd_q holds parent
				if ($signed(cur_q[63:32]) < $signed(rd_q[63:32])) begin
					we = 1'b1; wa = AW'(i_q); wd = rd_q;
					i_d = par; st_d = S_UP_RD;
				end else begin
					we = 1'b1; wa = AW'(i_q); st_d = S_DONE;
				end
			end
			S_RM_RD: begin
				ra = '0; st_d = S_RM_LAST;
			end
			S_RM_LAST: begin
				res_d = rd_q;
				ra = AW'(cnt_q);
				i_d = '0;
				// marks the first visit of the root, where rd_q is the moving entry
				best_d = '0;
				st_d = (cnt_q == '0) ? S_DONE : S_DN_PAR;
			end
			S_DN_PAR: begin
				// rd_q = moving entry (first time) already captured below
				if (i_q == '0 && c_q == '1) cur_d = cur_q;
				cur_d = (i_q == '0 && best_q != '1) ? rd_q : cur_q;
				best_d = '1;
				bestv_d = (i_q == '0 && best_q != '1) ? rd_q : cur_q;
				c_d = k * i_q + IW'(1);
				end_d = k * i_q + k;
				if (k * i_q + IW'(1) >= IW'(cnt_q)) begin
					we = 1'b1; wa = AW'(i_q);
					wd = (i_q == '0 && best_q != '1) ? rd_q : cur_q;
					st_d = S_DONE;
				end else begin
					ra = AW'(k * i_q + IW'(1));
					st_d = S_DN_CH;
				end
			end
			S_DN_CH: begin
				key_lt = ka < kb;
				if (key_lt) begin
					bestv_d = rd_q; best_d = c_q;
				end
				if (c_q == end_q || c_q + IW'(1) >= IW'(cnt_q)) begin
					st_d = S_DN_WR;
				end else begin
					c_d = c_q + IW'(1);
					ra = AW'(c_q + IW'(1));
				end
			end
			S_DN_WR: begin
				we = 1'b1; wa = AW'(i_q);
				if (best_q == '1) begin
					wd = cur_q; st_d = S_DONE;
				end else begin
					wd = bestv_q; i_d = best_q; st_d = S_DN_PAR;
				end
			end
			S_DONE: begin
				// hand the result over once the output register is free
				if (!ov_q || m_axis_tready) begin
					out_d = {3'b000, 11'(cnt_q), stat_q, res_q[63:32], res_q[31:0]};
					ov_d = 1'b1; st_d = S_IDLE;
				end
			end
			default: st_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE; cnt_q <= '0; ar_q <= ARITY_RESET; ov_q <= 1'b0;
			best_q <= '0;
		end else begin
			st_q <= st_d; cnt_q <= cnt_d; ov_q <= ov_d; best_q <= best_d;
			if (cfg_valid && cfg_ready) ar_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		i_q <= i_d; c_q <= c_d; end_q <= end_d; cur_q <= cur_d;
		bestv_q <= bestv_d; res_q <= res_d; stat_q <= stat_d; out_q <= out_d;
	end
endmodule
`default_nettype wire

### tb/tb_kary_min_heap_queue_top.sv
// Testbench for the k-ary min-heap queue: directed and random insert/remove traffic
// with random idling on both streams, checked against a local heap predictor.
// Depends on kmhq_pkg and kary_min_heap_queue_top.
module tb_kary_min_heap_queue_top;
	import kmhq_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAP = CAPACITY_DEF;
	localparam logic FN_INSERT = 1'b0;
	localparam logic FN_REMOVE = 1'b1;
	localparam int STALL_LIMIT = 20000;

	typedef struct packed {
		logic [10:0] count;
		status_t     status;
		logic [31:0] key;
		logic [31:0] elem;
	} heap_result_t;

	int err_count = 0;

	function automatic void report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
		err_count++;
	endfunction

	// Heap predictor plus queue of expected results
	class heap_scoreboard;
		logic [31:0] keys[CAP];
		logic [31:0] elems[CAP];
		int unsigned count;
		logic [3:0] arity_reg;
		heap_result_t pending[$];

		function new();
			count = 0;
			arity_reg = ARITY_RESET;
		endfunction

		function automatic bit key_lt(logic [31:0] a, logic [31:0] b);
			return $signed(a) < $signed(b);
		endfunction

		function automatic void swap_slots(int a, int b);
			logic [31:0] t;
			t = keys[a]; keys[a] = keys[b]; keys[b] = t;
			t = elems[a]; elems[a] = elems[b]; elems[b] = t;
		endfunction

		// one accepted operation
		function automatic void note_op(logic fn, logic [31:0] e, logic [31:0] k);
			int kk, i, p, first, best;
			heap_result_t r;
			kk = (arity_reg < 2) ? 2 : (arity_reg > MAX_ARITY_DEF) ? MAX_ARITY_DEF : arity_reg;
			r = '0;
			r.status = ST_OK;
			if (fn == FN_INSERT) begin
				if (count >= CAP) r.status = ST_FULL;
				else begin
					i = count;
					keys[i] = k; elems[i] = e;
					count++;
					while (i > 0) begin
						p = (i - 1) / kk;
						if (!key_lt(keys[i], keys[p])) break;
						swap_slots(i, p);
						i = p;
					end
				end
			end else if (count == 0) begin
				r.status = ST_EMPTY;
			end else begin
				r.elem = elems[0];
				r.key = keys[0];
				count--;
				if (count > 0) begin
					keys[0] = keys[count]; elems[0] = elems[count];
					i = 0;
					forever begin
						first = kk * i + 1;
						if (first >= count) break;
						best = i;
						for (int c = first; c < first + kk && c < count; c++)
							if (key_lt(keys[c], keys[best])) best = c;
						if (best == i) break;
						swap_slots(i, best);
						i = best;
					end
				end
			end
			r.count = 11'(count);
			pending = {pending, r};
		endfunction

		function automatic void check_result(logic [79:0] d);
			heap_result_t got, want;
			got = d[76:0];
			if (pending.size() == 0) begin
				report_mismatch("unexpected result", d[31:0], 0);
				return;
			end
			want = pending.pop_front();
			if (got.elem !== want.elem) report_mismatch("elem_out", got.elem, want.elem);
			if (got.key !== want.key) report_mismatch("key_out", got.key, want.key);
			if (got.status !== want.status) report_mismatch("status", got.status, want.status);
			if (got.count !== want.count) report_mismatch("count_out", got.count, want.count);
		endfunction
	endclass

	logic clk = 0, arst_n = 0;
	logic cfg_valid = 0, cfg_ready;
	logic [3:0] cfg_data = '0;
	logic s_axis_tvalid = 0, s_axis_tready, s_axis_tuser = 0;
	logic [63:0] s_axis_tdata = '0;
	logic m_axis_tvalid, m_axis_tready = 0;
	logic [79:0] m_axis_tdata;

	heap_scoreboard sb = new();
	bit calm = 0;      // no idling during this stretch
	bit sink_on = 0;
	int stall_cycles = 0;

	kary_min_heap_queue_top dut (.*);

	initial forever #5 clk = ~clk;

	// receiver with random stalls
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
		m_axis_tready <= sink_on && (calm || $urandom_range(99) >= 21);
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else if (arst_n) stall_cycles <= stall_cycles + 1;
		if (stall_cycles > STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// valid stays up after a transfer until the next operation or an idle cycle
	task automatic send_op(input logic fn, input logic [31:0] e, input logic [31:0] k);
		while (!calm && $urandom_range(99) < 21) begin
			s_axis_tvalid <= 0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tuser <= fn;
		s_axis_tdata <= {k, e};
		do @(posedge clk); while (!s_axis_tready);
		sb.note_op(fn, e, k);
	endtask

	task automatic drain();
		s_axis_tvalid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_arity(input logic [3:0] v);
		drain();
		cfg_valid <= 1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		sb.arity_reg = v;
	endtask

	function automatic logic [31:0] rand_key();
		case ($urandom_range(3))
			0: return $urandom_range(15);
			1: return 32'h8000_0000 + $urandom_range(3);
			2: return 32'h7FFF_FFFF - $urandom_range(3);
			default: return $urandom;
		endcase
	endfunction

	// random burst biased toward inserts or removes
	task automatic random_burst(input int n, input int ins_pct);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < ins_pct) send_op(FN_INSERT, $urandom, rand_key());
			else send_op(FN_REMOVE, $urandom, $urandom);
		end
	endtask

	initial begin
		logic [3:0] ar_set[6] = '{4'd2, 4'd8, 4'd0, 4'd15, 4'd5, 4'd1};
		repeat (7) @(posedge clk);
		arst_n <= 1;
		sink_on <= 1;
		@(posedge clk);

		// directed: empty remove, extremes, equal keys, drain past empty
		send_op(FN_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_op(FN_INSERT, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_op(FN_INSERT, 32'h8000_0000, 32'h8000_0000);
		send_op(FN_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_op(FN_INSERT, 32'h0, 32'h0);
		send_op(FN_INSERT, 32'h1234_5678, 32'h0);
		send_op(FN_INSERT, 32'h5555_5555, 32'h8000_0000);
		for (int i = 0; i < 8; i++) send_op(FN_REMOVE, 0, 0);
		write_arity(4'd3);

		// random phases across arity settings
		foreach (ar_set[a]) begin
			write_arity(ar_set[a]);
			calm = (a == 2);
			random_burst(12, 65);
			random_burst(8, 35);
		end
		calm = 0;

		// arity change while entries remain, then a remove-heavy burst
		random_burst(20, 90);
		write_arity(4'd7);
		random_burst(10, 20);
		write_arity(4'd4);

		// fill to capacity, first part without idling, hit full, then work down
		while (sb.count < CAP) begin
			calm = (sb.count < 300);
			send_op(FN_INSERT, $urandom, rand_key());
		end
		calm = 0;
		send_op(FN_INSERT, $urandom, $urandom);
		send_op(FN_INSERT, $urandom, $urandom);
		random_burst(8, 50);
		write_arity(4'd8);
		random_burst(12, 10);

		drain();
		if (err_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule
